@@ rtl/font_glyph_offset_lookup_assert.svh @@
// assertion macros shared by the glyph offset lookup modules
`ifndef FONT_GLYPH_OFFSET_LOOKUP_ASSERT_SVH
`define FONT_GLYPH_OFFSET_LOOKUP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FGOL_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("fgol assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define FGOL_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("fgol assertion failed");

`endif

@@ rtl/fgol_pkg.sv @@
// types, constants and microcode rom of the glyph offset lookup
`timescale 1ns / 1ps
package fgol_pkg;

	localparam int MAX_BLOCKS_DEF = 256;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	localparam logic [2:0] REG_WIDTH      = 3'd0;
	localparam logic [2:0] REG_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_DOUBLE     = 3'd2;
	localparam logic [2:0] REG_BLOCKS     = 3'd3;
	localparam logic [2:0] REG_SINGLE_OFF = 3'd4;
	localparam logic [2:0] REG_TABLE_OFF  = 3'd5;

	typedef logic [2:0] step_t;

	localparam step_t S_IDLE  = 3'd0;
	localparam step_t S_DISP  = 3'd1;
	localparam step_t S_SBMUL = 3'd2;
	localparam step_t S_WINIT = 3'd3;
	localparam step_t S_WRD   = 3'd4;
	localparam step_t S_CMP   = 3'd5;
	localparam step_t S_CMUL  = 3'd6;
	localparam step_t S_FIN   = 3'd7;

	typedef enum logic [2:0] {
		COND_NEXT      = 3'd0,
		COND_ALWAYS    = 3'd1,
		COND_NO_LOOKUP = 3'd2,
		COND_DOUBLE    = 3'd3,
		COND_END       = 3'd4,
		COND_MORE      = 3'd5,
		COND_OUT_BUSY  = 3'd6
	} cond_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  accept;
		logic  sb_mul;
		logic  walk_init;
		logic  rd;
		logic  cmp;
		logic  cnt_mul;
		logic  fin;
	} ctl_t;

	typedef struct packed {
		logic lookup;
		logic dbl;
		logic walk_end;
		logic more;
		logic out_busy;
	} sts_t;

	typedef struct packed {
		logic [7:0] width;
		logic [7:0] height;
		logic       dbl;
		logic [7:0] block_count;
		logic [7:0] single_off;
		logic [7:0] table_off;
	} cfg_t;

	function automatic ctl_t ucode(step_t s);
		ctl_t c;
		c = '0;
		c.cond = COND_NEXT;
		unique case (s)
			S_IDLE: begin
				c.accept = 1'b1;
				c.cond   = COND_NO_LOOKUP;
				c.target = S_IDLE;
			end
			S_DISP: begin
				c.cond   = COND_DOUBLE;
				c.target = S_WINIT;
			end
			S_SBMUL: begin
				c.sb_mul = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = S_FIN;
			end
			S_WINIT: begin
				c.walk_init = 1'b1;
			end
			S_WRD: begin
				c.rd     = 1'b1;
				c.cond   = COND_END;
				c.target = S_CMUL;
			end
			S_CMP: begin
				c.cmp    = 1'b1;
				c.rd     = 1'b1;
				c.cond   = COND_MORE;
				c.target = S_CMP;
			end
			S_CMUL: begin
				c.cnt_mul = 1'b1;
			end
			S_FIN: begin
				c.fin    = 1'b1;
				c.cond   = COND_OUT_BUSY;
				c.target = S_FIN;
			end
			default: begin
				c.cond   = COND_ALWAYS;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

@@ rtl/fgol_seq.sv @@
// microcode sequencer: step counter, rom and jump logic
`timescale 1ns / 1ps
`include "font_glyph_offset_lookup_assert.svh"
module fgol_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  fgol_pkg::sts_t sts,
	output fgol_pkg::ctl_t ctl
);
	import fgol_pkg::*;

	step_t upc_q;
	step_t upc_d;
	logic  take;

	assign ctl = ucode(upc_q);

	always_comb begin
		case (ctl.cond)
			COND_NEXT:      take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_LOOKUP: take = !sts.lookup;
			COND_DOUBLE:    take = sts.dbl;
			COND_END:       take = sts.walk_end;
			COND_MORE:      take = sts.more;
			COND_OUT_BUSY:  take = sts.out_busy;
			default:        take = 1'b0;
		endcase
		// last step wraps back to idle
		upc_d = take ? ctl.target : step_t'(upc_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	`FGOL_ASSERT_NEXT(a_jump_taken, ctl.cond == COND_ALWAYS, upc_q == $past(ctl.target))
	`FGOL_ASSERT_NEXT(a_lookup_leaves_idle, ctl.accept && sts.lookup, upc_q == S_DISP)

endmodule

@@ rtl/fgol_dp.sv @@
// datapath: block table memory, walk counters, shared multiplier, result register
`timescale 1ns / 1ps
`include "font_glyph_offset_lookup_assert.svh"
module fgol_dp #(
	parameter int MAX_BLOCKS = fgol_pkg::MAX_BLOCKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fgol_pkg::ctl_t ctl,
	input  fgol_pkg::cfg_t cfg,
	output fgol_pkg::sts_t sts,
	input  logic           item_valid,
	input  logic           kind,
	input  logic [15:0]    char_code,
	input  logic [7:0]     entry_index,
	input  logic [15:0]    range_first,
	input  logic [15:0]    range_last,
	output logic           result_valid,
	input  logic           result_ready,
	output logic           found,
	output logic [31:0]    glyph_offset,
	output logic [5:0]     row_pitch,
	output logic [12:0]    glyph_bytes
);
	import fgol_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PTR_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [8:0] MAXB = 9'(MAX_BLOCKS);

	logic [31:0] blk_mem [MAX_BLOCKS];
	logic [31:0] entry_s1;

	logic [15:0] code_q;
	logic [5:0]  pitch_q;
	logic [12:0] size_q;
	logic [PTR_W-1:0] ptr_q;
	logic [31:0] count_q;
	logic        hit_q;
	logic [31:0] base_q;
	logic [31:0] prod_q;

	logic        res_valid_q;
	logic        found_q;
	logic [31:0] off_q;
	logic [5:0]  rpitch_q;
	logic [12:0] rbytes_q;

	logic [8:0]       limit9;
	logic [PTR_W-1:0] limit;
	logic             more_ent;
	logic             rd_en;
	logic             wr_en;
	logic             acc_lookup;
	logic [15:0]      first;
	logic [15:0]      last;
	logic             match;
	logic [31:0]      cnt_add;
	logic [31:0]      mul_a;
	logic [31:0]      prod_w;
	logic [8:0]       wsum;
	logic [5:0]       pitch_w;
	logic [13:0]      size_full;
	logic             out_busy;

	assign limit9   = ({1'b0, cfg.block_count} >= MAXB) ? MAXB : {1'b0, cfg.block_count};
	assign limit    = limit9[PTR_W-1:0];
	assign more_ent = ptr_q < limit;
	assign rd_en    = ctl.rd && more_ent;

	assign acc_lookup = ctl.accept && item_valid && (kind == KIND_LOOKUP);
	assign wr_en      = ctl.accept && item_valid && (kind == KIND_LOAD)
	                    && ({1'b0, entry_index} < MAXB);

	assign first   = entry_s1[31:16];
	assign last    = entry_s1[15:0];
	assign match   = (code_q >= first) && (code_q <= last);
	assign cnt_add = match ? {16'd0, 16'(code_q - first)}
	                       : ({16'd0, last} - {16'd0, first} + 32'd1);

	assign mul_a  = ctl.cnt_mul ? count_q : {16'd0, code_q};
	assign prod_w = mul_a * {19'd0, size_q};

	assign wsum      = {1'b0, cfg.width} + 9'd7;
	assign pitch_w   = wsum[8:3];
	assign size_full = {8'd0, pitch_w} * {6'd0, cfg.height};

	assign out_busy = res_valid_q && !result_ready;

	assign sts.lookup   = item_valid && (kind == KIND_LOOKUP);
	assign sts.dbl      = cfg.dbl;
	assign sts.walk_end = !more_ent;
	assign sts.more     = !match && more_ent;
	assign sts.out_busy = out_busy;

	// block table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[entry_index[IDX_W-1:0]] <= {range_first, range_last};
		end
		if (rd_en) begin
			entry_s1 <= blk_mem[ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_lookup) begin
			code_q  <= char_code;
			pitch_q <= pitch_w;
			size_q  <= size_full[12:0];
		end
		if (ctl.sb_mul) begin
			base_q <= {24'd0, cfg.single_off};
		end else if (ctl.walk_init) begin
			base_q <= {24'd0, cfg.table_off} + {22'd0, cfg.block_count, 2'b00};
		end
		if (ctl.sb_mul || ctl.cnt_mul) begin
			prod_q <= prod_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.walk_init) begin
				ptr_q   <= '0;
				count_q <= '0;
				hit_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (ctl.cmp) begin
					count_q <= count_q + cnt_add;
					if (match) begin
						hit_q <= 1'b1;
					end
				end
				if (ctl.sb_mul) begin
					hit_q <= (code_q[15:8] == 8'd0);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.fin && !out_busy) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin && !out_busy) begin
			found_q  <= hit_q;
			off_q    <= hit_q ? (base_q + prod_q) : 32'd0;
			rpitch_q <= pitch_q;
			rbytes_q <= size_q;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign glyph_offset = off_q;
	assign row_pitch    = rpitch_q;
	assign glyph_bytes  = rbytes_q;

	`FGOL_ASSERT_IMP(a_cmp_after_read, ctl.cmp, ptr_q != '0 && ptr_q <= limit)
	`FGOL_ASSERT_IMP(a_miss_zero, res_valid_q && !found_q, off_q == 32'd0)
	`FGOL_ASSERT_NEXT(a_fin_loads, ctl.fin && !out_busy, res_valid_q)

endmodule

@@ rtl/font_glyph_offset_lookup.sv @@
// top level: apb register file, microcode sequencer and datapath
// a single-byte lookup runs the dispatch, multiply and finish steps after the item is taken;
// a double-byte lookup walks n table entries (n at most 255), then multiplies and finishes
// one lookup at a time: no new item is taken until the result register is loaded
// (the walk reads one table entry a cycle); a table load item is written while idle
// reset: registers return to their defaults, the table contents stay undefined
`timescale 1ns / 1ps
module font_glyph_offset_lookup #(
	parameter int MAX_BLOCKS = fgol_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        kind,
	input  logic [15:0] char_code,
	input  logic [7:0]  entry_index,
	input  logic [15:0] range_first,
	input  logic [15:0] range_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        found,
	output logic [31:0] glyph_offset,
	output logic [5:0]  row_pitch,
	output logic [12:0] glyph_bytes
);
	import fgol_pkg::*;

	cfg_t       cfg_q;
	ctl_t       ctl;
	sts_t       sts;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width       <= 8'd8;
			cfg_q.height      <= 8'd16;
			cfg_q.dbl         <= 1'b0;
			cfg_q.block_count <= 8'd0;
			cfg_q.single_off  <= 8'd17;
			cfg_q.table_off   <= 8'd18;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH:      cfg_q.width       <= pwdata[7:0];
				REG_HEIGHT:     cfg_q.height      <= pwdata[7:0];
				REG_DOUBLE:     cfg_q.dbl         <= pwdata[0];
				REG_BLOCKS:     cfg_q.block_count <= pwdata[7:0];
				REG_SINGLE_OFF: cfg_q.single_off  <= pwdata[7:0];
				REG_TABLE_OFF:  cfg_q.table_off   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:      prdata = {24'd0, cfg_q.width};
			REG_HEIGHT:     prdata = {24'd0, cfg_q.height};
			REG_DOUBLE:     prdata = {31'd0, cfg_q.dbl};
			REG_BLOCKS:     prdata = {24'd0, cfg_q.block_count};
			REG_SINGLE_OFF: prdata = {24'd0, cfg_q.single_off};
			REG_TABLE_OFF:  prdata = {24'd0, cfg_q.table_off};
			default:        prdata = 32'd0;
		endcase
	end

	assign item_ready = ctl.accept;

	fgol_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	fgol_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg_q),
		.sts          (sts),
		.item_valid   (item_valid),
		.kind         (kind),
		.char_code    (char_code),
		.entry_index  (entry_index),
		.range_first  (range_first),
		.range_last   (range_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.found        (found),
		.glyph_offset (glyph_offset),
		.row_pitch    (row_pitch),
		.glyph_bytes  (glyph_bytes)
	);

endmodule
